FILE: hdl/bbc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbc_pkg
// Shared types, field widths and codes of the block buffer cache engine.
// ----------------------------------------------------------------------------
package bbc_pkg;

    // Field widths of the command and result transfers
    localparam int KIND_FIELD_W   = 3;
    localparam int BLK_FIELD_W    = 24;
    localparam int IDX_FIELD_W    = 4;
    localparam int STATUS_FIELD_W = 3;
    localparam int SLOT_FIELD_W   = 4;

    // Default sizing
    localparam int NUM_BUFFERS_DEF = 16;
    localparam int BLOCK_BITS_DEF  = 24;

    // Command kinds
    localparam logic [KIND_FIELD_W-1:0] KIND_GET     = 3'd0;
    localparam logic [KIND_FIELD_W-1:0] KIND_RELEASE = 3'd1;
    localparam logic [KIND_FIELD_W-1:0] KIND_DWRITE  = 3'd2;
    localparam logic [KIND_FIELD_W-1:0] KIND_WNOW    = 3'd3;
    localparam logic [KIND_FIELD_W-1:0] KIND_FILL    = 3'd4;
    localparam logic [KIND_FIELD_W-1:0] KIND_FLUSH   = 3'd5;

    // Result status codes
    localparam logic [STATUS_FIELD_W-1:0] ST_HIT   = 3'd0;
    localparam logic [STATUS_FIELD_W-1:0] ST_ALLOC = 3'd1;
    localparam logic [STATUS_FIELD_W-1:0] ST_BUSY  = 3'd2;
    localparam logic [STATUS_FIELD_W-1:0] ST_NONE  = 3'd3;
    localparam logic [STATUS_FIELD_W-1:0] ST_WB    = 3'd4;
    localparam logic [STATUS_FIELD_W-1:0] ST_DONE  = 3'd5;

    // Free list operations, one per cycle
    typedef enum logic [1:0] {
        LST_NOP,
        LST_APPEND,
        LST_REMOVE,
        LST_MOVE_TAIL
    } t_list_op;

    typedef struct packed {
        logic [KIND_FIELD_W-1:0] kind;
        logic [BLK_FIELD_W-1:0]  block_number;
        logic [IDX_FIELD_W-1:0]  buffer_index;
    } t_cmd;

    typedef struct packed {
        logic [STATUS_FIELD_W-1:0] status;
        logic [SLOT_FIELD_W-1:0]   buf_slot;
        logic [BLK_FIELD_W-1:0]    disk_block;
        logic                      data_present;
        logic                      last;
    } t_res;

endpackage

FILE: hdl/bbc_free_list.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbc_free_list
// Ordered free list of buffer slots; head is the least recently released.
// Takes one append, remove-at-position or move-to-tail operation a cycle.
// ----------------------------------------------------------------------------
module bbc_free_list
    import bbc_pkg::*;
#(
    parameter int NUM_BUFFERS = NUM_BUFFERS_DEF,
    localparam int SlotW = $clog2(NUM_BUFFERS),
    localparam int CntW  = $clog2(NUM_BUFFERS + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_list_op         i_op,
    input  logic [SlotW-1:0] i_pos,
    input  logic [SlotW-1:0] i_entry,
    output logic [SlotW-1:0] o_head,
    output logic [SlotW-1:0] o_at_pos,
    output logic [CntW-1:0]  o_count
);

    logic [SlotW-1:0] r_list [NUM_BUFFERS];
    logic [SlotW-1:0] n_list [NUM_BUFFERS];
    logic [CntW-1:0]  r_count;
    logic [CntW-1:0]  n_count;

    // Shift entries behind the chosen position toward the head; place appended or moved entry at tail
    always_comb begin
        n_count = r_count;
        for (int j = 0; j < NUM_BUFFERS; j++) begin
            n_list[j] = r_list[j];
        end
        case (i_op)
            LST_APPEND: begin
                for (int j = 0; j < NUM_BUFFERS; j++) begin
                    if (j == int'(r_count)) begin
                        n_list[j] = i_entry;
                    end
                end
                n_count = r_count + CntW'(1);
            end
            LST_REMOVE: begin
                for (int j = 0; j < NUM_BUFFERS - 1; j++) begin
                    if (j >= int'(i_pos) && j < int'(r_count) - 1) begin
                        n_list[j] = r_list[j + 1];
                    end
                end
                n_count = r_count - CntW'(1);
            end
            LST_MOVE_TAIL: begin
                for (int j = 0; j < NUM_BUFFERS - 1; j++) begin
                    if (j >= int'(i_pos) && j < int'(r_count) - 1) begin
                        n_list[j] = r_list[j + 1];
                    end
                end
                for (int j = 0; j < NUM_BUFFERS; j++) begin
                    if (j == int'(r_count) - 1) begin
                        n_list[j] = r_list[i_pos];
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Hold list and count; reset puts every slot on the list in order
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < NUM_BUFFERS; j++) begin
                r_list[j] <= SlotW'(j);
            end
            r_count <= CntW'(NUM_BUFFERS);
        end else begin
            r_list  <= n_list;
            r_count <= n_count;
        end
    end

    assign o_head   = r_list[0];
    assign o_at_pos = r_list[i_pos];
    assign o_count  = r_count;

endmodule

FILE: hdl/block_buffer_cache_lru.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_buffer_cache_lru
// Tag and replacement engine of a disk block buffer cache with delayed write
// and a least recently released free list. One tag/slot comparator is shared
// by a small sequencer for lookup and free-list search.
// ----------------------------------------------------------------------------
//  channel  | ports                        | transfer when
//  ---------+------------------------------+----------------------------------
//  command  | start, busy, i_cmd           | start high while busy low
//  result   | o_strobe, o_result           | every cycle o_strobe is high
//
//  Sequence (N buffers): a get steps the tag RAM to the matching slot, then
//  the free list to that slot's place; a get miss steps all N slots, then
//  writes back each dirty head before allocating a clean one. A flush writes
//  back each dirty free buffer; release, write, fill and unknown kinds act
//  at once. The comparator steps one entry a cycle; the tag read is registered.
//  Reset is synchronous; the engine is ready in the cycle after reset.
//  Results are shown one cycle each and cannot be held off.
// ----------------------------------------------------------------------------
module block_buffer_cache_lru
    import bbc_pkg::*;
#(
    parameter int NUM_BUFFERS = NUM_BUFFERS_DEF,
    parameter int BLOCK_BITS  = BLOCK_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_cmd i_cmd,
    output logic busy,
    output logic o_strobe,
    output t_res o_result
);

    localparam int SlotW = $clog2(NUM_BUFFERS);
    localparam int CntW  = $clog2(NUM_BUFFERS + 1);
    localparam int TagW  = (BLOCK_BITS < BLK_FIELD_W) ? BLOCK_BITS : BLK_FIELD_W;
    localparam int CmpW  = (TagW > SlotW) ? TagW : SlotW;
    localparam logic [SlotW-1:0] LastSlot = SlotW'(NUM_BUFFERS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOKUP,
        S_HIT_SCAN,
        S_MISS_HEAD,
        S_MISS_WB,
        S_FLUSH_SCAN,
        S_FLUSH_WB,
        S_ACT
    } t_state;

    t_state r_state, n_state;

    logic [KIND_FIELD_W-1:0] r_kind, n_kind;
    logic [TagW-1:0]         r_blk, n_blk;
    logic [IDX_FIELD_W-1:0]  r_idx, n_idx;
    logic [SlotW-1:0]        r_slot, n_slot;
    logic [SlotW-1:0]        r_ptr, n_ptr;
    logic [CntW-1:0]         r_pos, n_pos;
    logic [CntW-1:0]         r_left, n_left;

    logic [NUM_BUFFERS-1:0] r_valid, n_valid;
    logic [NUM_BUFFERS-1:0] r_held, n_held;
    logic [NUM_BUFFERS-1:0] r_dirty, n_dirty;
    logic [NUM_BUFFERS-1:0] r_present, n_present;

    logic [TagW-1:0]  r_tag_mem [NUM_BUFFERS];
    logic [TagW-1:0]  r_tag_q;
    logic [SlotW-1:0] r_tag_idx;
    logic [SlotW-1:0] rd_addr;
    logic             wr_en;
    logic [SlotW-1:0] wr_addr;

    t_list_op         list_op;
    logic [SlotW-1:0] list_pos;
    logic [SlotW-1:0] list_entry;
    logic [SlotW-1:0] list_head;
    logic [SlotW-1:0] list_at;
    logic [CntW-1:0]  list_count;

    logic [CmpW-1:0] cmp_a;
    logic [CmpW-1:0] cmp_b;
    logic            cmp_eq;

    logic             idx_ok;
    logic [SlotW-1:0] idx_slot;

    logic r_strobe, n_strobe;
    t_res r_res, n_res;

    function automatic t_res make_res(
        input logic [STATUS_FIELD_W-1:0] status,
        input logic [SLOT_FIELD_W-1:0]   slot,
        input logic [BLK_FIELD_W-1:0]    blk,
        input logic                      pres,
        input logic                      last
    );
        t_res res;
        res.status       = status;
        res.buf_slot     = slot;
        res.disk_block   = blk;
        res.data_present = pres;
        res.last         = last;
        return res;
    endfunction

    bbc_free_list #(
        .NUM_BUFFERS (NUM_BUFFERS)
    ) u_free_list (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_op     (list_op),
        .i_pos    (list_pos),
        .i_entry  (list_entry),
        .o_head   (list_head),
        .o_at_pos (list_at),
        .o_count  (list_count)
    );

    // Shared comparator
    assign cmp_eq = (cmp_a == cmp_b);

    assign idx_ok   = (int'(r_idx) < NUM_BUFFERS);
    assign idx_slot = SlotW'(r_idx);

    // Sequencer next-state and datapath control
    always_comb begin
        n_state    = r_state;
        n_kind     = r_kind;
        n_blk      = r_blk;
        n_idx      = r_idx;
        n_slot     = r_slot;
        n_ptr      = r_ptr;
        n_pos      = r_pos;
        n_left     = r_left;
        n_valid    = r_valid;
        n_held     = r_held;
        n_dirty    = r_dirty;
        n_present  = r_present;
        n_strobe   = 1'b0;
        n_res      = r_res;
        list_op    = LST_NOP;
        list_pos   = r_pos[SlotW-1:0];
        list_entry = r_slot;
        wr_en      = 1'b0;
        wr_addr    = r_slot;
        rd_addr    = r_ptr;
        cmp_a      = CmpW'(r_tag_q);
        cmp_b      = CmpW'(r_blk);

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_kind = i_cmd.kind;
                    n_blk  = TagW'(i_cmd.block_number);
                    n_idx  = i_cmd.buffer_index;
                    if (i_cmd.kind == KIND_GET) begin
                        rd_addr = '0;
                        n_ptr   = SlotW'(1);
                        n_state = S_LOOKUP;
                    end else if (i_cmd.kind == KIND_FLUSH) begin
                        n_pos   = '0;
                        n_left  = list_count;
                        n_state = S_FLUSH_SCAN;
                    end else begin
                        rd_addr = SlotW'(i_cmd.buffer_index);
                        n_state = S_ACT;
                    end
                end
            end

            // Step the tag RAM one entry a cycle against the requested block
            S_LOOKUP: begin
                if (r_valid[r_tag_idx] && cmp_eq) begin
                    if (r_held[r_tag_idx]) begin
                        n_strobe = 1'b1;
                        n_res    = make_res(ST_BUSY, SLOT_FIELD_W'(r_tag_idx),
                                            BLK_FIELD_W'(r_blk),
                                            r_present[r_tag_idx], 1'b1);
                        n_state  = S_IDLE;
                    end else begin
                        n_slot  = r_tag_idx;
                        n_pos   = '0;
                        n_state = S_HIT_SCAN;
                    end
                end else if (r_tag_idx == LastSlot) begin
                    n_state = S_MISS_HEAD;
                end else if (r_ptr != LastSlot) begin
                    n_ptr = r_ptr + SlotW'(1);
                end
            end

            // Find the hit slot's place in the free list and take it out
            S_HIT_SCAN: begin
                cmp_a = CmpW'(list_at);
                cmp_b = CmpW'(r_slot);
                if (cmp_eq) begin
                    list_op         = LST_REMOVE;
                    n_held[r_slot]  = 1'b1;
                    n_strobe        = 1'b1;
                    n_res           = make_res(ST_HIT, SLOT_FIELD_W'(r_slot),
                                               BLK_FIELD_W'(r_blk),
                                               r_present[r_slot], 1'b1);
                    n_state         = S_IDLE;
                end else begin
                    n_pos = r_pos + CntW'(1);
                end
            end

            // Allocate the head, or write back a dirty head first
            S_MISS_HEAD: begin
                rd_addr = list_head;
                if (list_count == '0) begin
                    n_strobe = 1'b1;
                    n_res    = make_res(ST_NONE, '0, BLK_FIELD_W'(r_blk), 1'b0, 1'b1);
                    n_state  = S_IDLE;
                end else if (r_dirty[list_head]) begin
                    n_slot  = list_head;
                    n_state = S_MISS_WB;
                end else begin
                    list_op              = LST_REMOVE;
                    list_pos             = '0;
                    n_held[list_head]    = 1'b1;
                    n_dirty[list_head]   = 1'b0;
                    n_present[list_head] = 1'b0;
                    n_valid[list_head]   = 1'b1;
                    wr_en                = 1'b1;
                    wr_addr              = list_head;
                    n_strobe             = 1'b1;
                    n_res                = make_res(ST_ALLOC, SLOT_FIELD_W'(list_head),
                                                    BLK_FIELD_W'(r_blk), 1'b0, 1'b1);
                    n_state              = S_IDLE;
                end
            end

            // Write back the head, clean it and rotate it to the tail
            S_MISS_WB: begin
                n_dirty[r_slot] = 1'b0;
                list_op         = LST_MOVE_TAIL;
                list_pos        = '0;
                n_strobe        = 1'b1;
                n_res           = make_res(ST_WB, SLOT_FIELD_W'(r_slot),
                                           BLK_FIELD_W'(r_tag_q),
                                           r_present[r_slot], 1'b0);
                n_state         = S_MISS_HEAD;
            end

            // Walk the free list; leave clean entries, move dirty ones to the tail
            S_FLUSH_SCAN: begin
                rd_addr = list_at;
                if (r_left == '0) begin
                    n_strobe = 1'b1;
                    n_res    = make_res(ST_DONE, '0, '0, 1'b0, 1'b1);
                    n_state  = S_IDLE;
                end else if (r_dirty[list_at]) begin
                    n_slot  = list_at;
                    n_state = S_FLUSH_WB;
                end else begin
                    n_pos  = r_pos + CntW'(1);
                    n_left = r_left - CntW'(1);
                end
            end

            // Write back a dirty free buffer and move it behind the clean ones
            S_FLUSH_WB: begin
                n_dirty[r_slot] = 1'b0;
                list_op         = LST_MOVE_TAIL;
                n_left          = r_left - CntW'(1);
                n_strobe        = 1'b1;
                n_res           = make_res(ST_WB, SLOT_FIELD_W'(r_slot),
                                           BLK_FIELD_W'(r_tag_q),
                                           r_present[r_slot], 1'b0);
                n_state         = S_FLUSH_SCAN;
            end

            // Release, write, fill and unknown kinds
            S_ACT: begin
                n_strobe   = 1'b1;
                n_state    = S_IDLE;
                list_entry = idx_slot;
                if (!(r_kind inside {KIND_RELEASE, KIND_DWRITE, KIND_WNOW, KIND_FILL})) begin
                    n_res = make_res(ST_DONE, '0, '0, 1'b0, 1'b1);
                end else if (!idx_ok) begin
                    n_res = make_res(ST_DONE, r_idx, '0, 1'b0, 1'b1);
                end else if (!r_held[idx_slot]) begin
                    n_res = make_res(ST_DONE, r_idx, '0, r_present[idx_slot], 1'b1);
                end else begin
                    case (r_kind)
                        KIND_RELEASE: begin
                            n_held[idx_slot] = 1'b0;
                            list_op          = LST_APPEND;
                            n_res = make_res(ST_DONE, r_idx, '0, r_present[idx_slot], 1'b1);
                        end
                        KIND_DWRITE: begin
                            n_held[idx_slot]    = 1'b0;
                            n_dirty[idx_slot]   = 1'b1;
                            n_present[idx_slot] = 1'b1;
                            list_op             = LST_APPEND;
                            n_res = make_res(ST_DONE, r_idx, '0, 1'b1, 1'b1);
                        end
                        KIND_WNOW: begin
                            n_held[idx_slot]  = 1'b0;
                            n_dirty[idx_slot] = 1'b0;
                            list_op           = LST_APPEND;
                            n_res = make_res(ST_WB, r_idx, BLK_FIELD_W'(r_tag_q),
                                             r_present[idx_slot], 1'b1);
                        end
                        default: begin
                            n_present[idx_slot] = 1'b1;
                            n_res = make_res(ST_DONE, r_idx, '0, 1'b1, 1'b1);
                        end
                    endcase
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state, captured command, flags and the registered result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_strobe  <= 1'b0;
            r_valid   <= '0;
            r_held    <= '0;
            r_dirty   <= '0;
            r_present <= '0;
        end else begin
            r_state   <= n_state;
            r_strobe  <= n_strobe;
            r_valid   <= n_valid;
            r_held    <= n_held;
            r_dirty   <= n_dirty;
            r_present <= n_present;
        end
        r_res  <= n_res;
        r_kind <= n_kind;
        r_blk  <= n_blk;
        r_idx  <= n_idx;
        r_slot <= n_slot;
        r_ptr  <= n_ptr;
        r_pos  <= n_pos;
        r_left <= n_left;
    end

    // Tag RAM: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_tag_mem[wr_addr] <= r_blk;
        end
        r_tag_q   <= r_tag_mem[rd_addr];
        r_tag_idx <= rd_addr;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_res;

endmodule
